[rtl/irdc_pkg.sv]
// Shared constants and types for the integer-to-radix-digits converter.
package irdc_pkg;

   localparam int VALUE_W           = 32;
   localparam int LANES             = 32;                 // radix 2 needs one lane per bit
   localparam int LANE_IDX_W        = $clog2(LANES);
   localparam int COUNT_W           = $clog2(LANES + 1);
   localparam int RADIX_W           = 5;
   localparam int CHAR_W            = 8;
   localparam int ALPHA_ENTRIES     = 16;
   localparam int ALPHA_IDX_W       = $clog2(ALPHA_ENTRIES);
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_INDEX_W       = 2;
   localparam int DEFAULT_MAX_RADIX = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic clear;
      logic step;
      logic bit_in;
   } conv_ctrl_type;

endpackage

[rtl/irdc_convert.sv]
// Radix-r digit lanes: shifts the magnitude in one bit per cycle while step is set, MSB first.
module irdc_convert #(
   parameter int MAX_RADIX = irdc_pkg::DEFAULT_MAX_RADIX
) (
   input  logic                           clock,
   input  logic                           reset,
   input  irdc_pkg::conv_ctrl_type        ctrl,
   input  logic [irdc_pkg::RADIX_W-1:0]   radix,
   input  logic [irdc_pkg::LANE_IDX_W-1:0] rd_index,
   output logic [$clog2(MAX_RADIX)-1:0]   rd_digit,
   output logic [irdc_pkg::COUNT_W-1:0]   count
);
   import irdc_pkg::*;

   localparam int DW = $clog2(MAX_RADIX);

   logic [DW-1:0]      digit_ff [LANES];
   logic [DW-1:0]      digit_in [LANES];
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [DW:0]        r_n;
   logic [DW:0]        half;
   logic               odd;
   logic [LANES-1:0]   gen;
   logic [LANES-1:0]   prop;
   logic [LANES:0]     sum;
   logic [LANES:0]     carry;

   assign r_n  = radix[DW:0];
   assign half = r_n >> 1;
   assign odd  = r_n[0];

   // Doubling a lane carries out when it reaches half the radix; for an odd radix
   // a lane sitting exactly at the midpoint carries only if a carry comes in.
   // The carry prefix is resolved with one adder.
   always_comb begin
      logic [DW:0] dk;
      for (int k = 0; k < LANES; k++) begin
         dk      = {1'b0, digit_ff[k]};
         gen[k]  = odd ? (dk > half) : (dk >= half);
         prop[k] = odd && (dk == half);
      end
      sum   = {1'b0, gen | prop} + {1'b0, gen} + {{LANES{1'b0}}, ctrl.bit_in};
      carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
   end

   always_comb begin
      logic [DW+1:0] wide;
      for (int k = 0; k < LANES; k++) begin
         wide = {1'b0, digit_ff[k], 1'b0} + {{(DW+1){1'b0}}, carry[k]}
              - (carry[k+1] ? {1'b0, r_n} : '0);
         digit_in[k] = wide[DW-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = COUNT_W'(1);
      end else if (ctrl.step && carry[count_ff] && count_ff != COUNT_W'(LANES)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (ctrl.clear) begin
            digit_ff[k] <= '0;
         end else if (ctrl.step) begin
            digit_ff[k] <= digit_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_digit = digit_ff[rd_index];
   assign count    = count_ff;

endmodule

[rtl/integer_to_radix_digits_core.sv]
// After accept the item is converted in the digit lanes, then one character per cycle
// (sign first if negative) is sent while the result side takes them.
// The conversion length is set by the bit-serial digit lanes, one magnitude bit a cycle.
// One item is in work at a time; the next is accepted once the final character is loaded.
// Synchronous active-high reset clears the state, the output valid, radix, alphabet and config check.
// With an invalid radix or alphabet an item is consumed and gives no characters.
module integer_to_radix_digits_core #(
   parameter int MAX_RADIX = irdc_pkg::DEFAULT_MAX_RADIX
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [irdc_pkg::VALUE_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [irdc_pkg::CHAR_W-1:0]     rsp_character,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [irdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [irdc_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import irdc_pkg::*;

   localparam int DW = $clog2(MAX_RADIX);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [RADIX_W-1:0]                  radix_ff;
   logic [ALPHA_ENTRIES-1:0][CHAR_W-1:0] alphabet_ff;
   logic                                cfg_ok_ff, cfg_ok_in;
   logic [VALUE_W-1:0]                  mag_ff, mag_in;
   logic                                neg_ff, neg_in;
   logic [LANE_IDX_W-1:0]               bit_cnt_ff, bit_cnt_in;
   logic [LANE_IDX_W-1:0]               ptr_ff, ptr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                   rsp_character_ff, rsp_character_in;
   logic                                rsp_last_ff, rsp_last_in;

   conv_ctrl_type                       conv_ctrl;
   logic [DW-1:0]                       rd_digit;
   logic [COUNT_W-1:0]                  digit_count;
   logic                                out_free;
   logic [VALUE_W-1:0]                  raw;

   irdc_convert #(
      .MAX_RADIX (MAX_RADIX)
   ) u_convert (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (conv_ctrl),
      .radix    (radix_ff),
      .rd_index (ptr_ff),
      .rd_digit (rd_digit),
      .count    (digit_count)
   );

   // Config check: radix in 2..MAX_RADIX; every used entry must be distinct and not a sign or NUL.
   always_comb begin
      cfg_ok_in = (radix_ff >= RADIX_W'(2)) && (radix_ff <= RADIX_W'(MAX_RADIX));
      for (int i = 0; i < ALPHA_ENTRIES; i++) begin
         if (RADIX_W'(i) < radix_ff) begin
            if (alphabet_ff[i] == CHAR_NUL || alphabet_ff[i] == CHAR_PLUS
                || alphabet_ff[i] == CHAR_MINUS) begin
               cfg_ok_in = 1'b0;
            end
            for (int j = i + 1; j < ALPHA_ENTRIES; j++) begin
               if (RADIX_W'(j) < radix_ff && alphabet_ff[j] == alphabet_ff[i]) begin
                  cfg_ok_in = 1'b0;
               end
            end
         end
      end
   end

   assign raw       = req_value;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      bit_cnt_in       = bit_cnt_ff;
      ptr_in           = ptr_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      conv_ctrl        = '{clear: 1'b0, step: 1'b0, bit_in: mag_ff[VALUE_W-1]};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in          = raw[VALUE_W-1];
               mag_in          = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
               bit_cnt_in      = '0;
               conv_ctrl.clear = 1'b1;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            conv_ctrl.step = 1'b1;
            mag_in         = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in     = bit_cnt_ff + LANE_IDX_W'(1);
            if (bit_cnt_ff == LANE_IDX_W'(LANES - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ptr_in = LANE_IDX_W'(digit_count - COUNT_W'(1));
            if (!cfg_ok_ff) begin
               state_in = ST_IDLE;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = alphabet_ff[ALPHA_IDX_W'(rd_digit)];
               rsp_last_in      = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - LANE_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ok_ff    <= 1'b0;
         radix_ff     <= '0;
         alphabet_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ok_ff    <= cfg_ok_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RADIX:      radix_ff          <= csr_write_data[RADIX_W-1:0];
               CSR_ALPHA_LOW:  alphabet_ff[7:0]  <= csr_write_data;
               CSR_ALPHA_HIGH: alphabet_ff[15:8] <= csr_write_data;
               default: begin
                  // drop writes beyond the register list
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      bit_cnt_ff       <= bit_cnt_in;
      ptr_ff           <= ptr_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
